@@ sv/lmc_pkg.sv @@
package lmc_pkg;

  // Label space and table geometry.
  localparam int LABEL_W          = 16;
  localparam int MAX_REAL_LABEL   = 4095;
  localparam int OCEAN_LABEL      = 65534;
  localparam int IMPASSABLE_LABEL = 65535;
  localparam int TABLE_DEPTH      = MAX_REAL_LABEL + 1;
  localparam int ADDR_W           = $clog2(TABLE_DEPTH);
  localparam int COLOR_W          = 24;
  localparam int NUM_LANES        = 3;

  // Colors as 0xRRGGBB.
  localparam logic [COLOR_W-1:0] COLOR_WATER   = 24'h5BADFF;
  localparam logic [COLOR_W-1:0] COLOR_WASTE   = 24'hAAAAAA;
  localparam logic [COLOR_W-1:0] COLOR_IMPASS  = 24'h473A28;
  localparam logic [COLOR_W-1:0] COLOR_OUTLINE = 24'h7F7F7F;
  localparam logic [COLOR_W-1:0] COLOR_WHITE   = 24'hFFFFFF;

  // Operation codes of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register map.
  localparam int PADDR_W = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_ENABLE        = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_SEAS          = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_BETWEEN_WASTE = 2'd2;

  // One attribute table entry; sea is bit 0.
  typedef struct packed {
    logic [COLOR_W-1:0] fill;
    logic               has_fill;
    logic               titled;
    logic               sea;
  } entry_t;

  // What one lane reports about its label.
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               water;
    logic               waste;
    logic [COLOR_W-1:0] color;
  } lane_info_t;

  // Outline settings handed to the merge stage.
  typedef struct packed {
    logic outline_enable;
    logic outline_seas;
    logic outline_between_waste;
  } cfg_t;

endpackage

@@ sv/lmc_if.sv @@
interface lmc_in_if;
  import lmc_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [LABEL_W-1:0] pixel_label;
  logic [LABEL_W-1:0] right_label;
  logic [LABEL_W-1:0] below_label;
  logic               entry_sea;
  logic               entry_titled;
  logic               entry_has_fill;
  logic [COLOR_W-1:0] entry_fill;

  modport source (output valid, operation, pixel_label, right_label, below_label,
                  entry_sea, entry_titled, entry_has_fill, entry_fill, input ready);
  modport sink (input valid, operation, pixel_label, right_label, below_label,
                entry_sea, entry_titled, entry_has_fill, entry_fill, output ready);
endinterface

interface lmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       outlined;

  modport source (output valid, blue, green, red, outlined, input ready);
  modport sink (input valid, blue, green, red, outlined, output ready);
endinterface

@@ sv/lmc_lane.sv @@
module lmc_lane
  import lmc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  entry_t             wr_data,
  input  logic [LABEL_W-1:0] rd_label,
  output lane_info_t         info
);

  // Private copy of the attribute table; every lane receives every load.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata;
  logic [LABEL_W-1:0] label;
  logic               is_real;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rdata <= mem[rd_label[ADDR_W-1:0]];
      label <= rd_label;
    end
  end

  // Classify the label from its entry or from its reserved value.
  assign is_real = (32'(label) <= MAX_REAL_LABEL);

  always_comb begin
    info.label = label;
    info.water = (32'(label) == OCEAN_LABEL) || (is_real && rdata.sea);
    info.waste = is_real && !rdata.sea && !rdata.titled;
    priority if (is_real) begin
      priority if (rdata.has_fill) info.color = rdata.fill;
      else if (rdata.sea)          info.color = COLOR_WATER;
      else if (!rdata.titled)      info.color = COLOR_WASTE;
      else                         info.color = COLOR_WHITE;
    end else if (32'(label) == OCEAN_LABEL) begin
      info.color = COLOR_WATER;
    end else if (32'(label) == IMPASSABLE_LABEL) begin
      info.color = COLOR_IMPASS;
    end else begin
      info.color = COLOR_WHITE;
    end
  end

endmodule

@@ sv/lmc_merge.sv @@
module lmc_merge
  import lmc_pkg::*;
(
  input  cfg_t               cfg,
  input  lane_info_t         lane [NUM_LANES],
  output logic [COLOR_W-1:0] color,
  output logic               outlined
);

  logic differ;
  logic merged;
  logic land;

  // A boundary exists unless all three labels agree.
  assign differ = !((lane[0].label == lane[1].label) && (lane[0].label == lane[2].label));

  // Wasteland regions run together unless asked to keep their borders.
  assign merged = !cfg.outline_between_waste && lane[0].waste && lane[1].waste && lane[2].waste;

  // Water-only boundaries need the sea outline setting.
  assign land = !(lane[0].water && lane[1].water && lane[2].water);

  assign outlined = cfg.outline_enable && differ && !merged && (land || cfg.outline_seas);
  assign color    = outlined ? COLOR_OUTLINE : lane[0].color;

endmodule

@@ sv/label_map_color_and_outline_top.sv @@
// A render word is registered into the lookup stage (table read) when the input accepts it,
// then into the output register, which offers it on the output. One word per clock unless
// the output is held; the three table lookups run in parallel lane copies. A load word
// writes all table copies at its accept edge if its label is real, and yields no output word.
// Reset clears the pipeline valid flags and the outline settings (enable 1, others 0).
// The attribute table is not cleared; entries read before being loaded are undefined.
module label_map_color_and_outline_top
  import lmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lmc_in_if.sink             pix_in,
  lmc_out_if.source          pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t               cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               cfg_write;
  logic               accept;
  logic               advance;
  logic               load_we;
  logic               s1_valid;
  entry_t             wr_entry;
  lane_info_t         lane_info [NUM_LANES];
  logic [LABEL_W-1:0] lane_label [NUM_LANES];
  logic [COLOR_W-1:0] merge_color;
  logic               merge_outlined;
  logic [COLOR_W-1:0] out_color;
  logic               out_valid;
  logic               out_outlined;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outline_enable        <= 1'b1;
      cfg.outline_seas          <= 1'b0;
      cfg.outline_between_waste <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_OUTLINE_ENABLE:        cfg.outline_enable        <= pwdata[0];
        REG_OUTLINE_SEAS:          cfg.outline_seas          <= pwdata[0];
        REG_OUTLINE_BETWEEN_WASTE: cfg.outline_between_waste <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OUTLINE_ENABLE:        prdata = {31'b0, cfg.outline_enable};
      REG_OUTLINE_SEAS:          prdata = {31'b0, cfg.outline_seas};
      REG_OUTLINE_BETWEEN_WASTE: prdata = {31'b0, cfg.outline_between_waste};
      default:                   prdata = '0;
    endcase
  end

  // Pipeline flow: the lookup stage moves whenever the output register is free.
  assign advance      = !out_valid || pix_out.ready;
  assign pix_in.ready = !s1_valid || advance;
  assign accept       = pix_in.valid && pix_in.ready;
  assign load_we      = accept && (pix_in.operation == OP_LOAD)
                        && (32'(pix_in.pixel_label) <= MAX_REAL_LABEL);

  assign wr_entry.fill     = pix_in.entry_fill;
  assign wr_entry.has_fill = pix_in.entry_has_fill;
  assign wr_entry.titled   = pix_in.entry_titled;
  assign wr_entry.sea      = pix_in.entry_sea;

  assign lane_label[0] = pix_in.pixel_label;
  assign lane_label[1] = pix_in.right_label;
  assign lane_label[2] = pix_in.below_label;

  // One lookup lane per label of the word.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lmc_lane u_lane (
      .clk      (clk),
      .en       (accept),
      .we       (load_we),
      .wr_addr  (pix_in.pixel_label[ADDR_W-1:0]),
      .wr_data  (wr_entry),
      .rd_label (lane_label[g]),
      .info     (lane_info[g])
    );
  end

  // Only render words travel down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= accept && (pix_in.operation == OP_RENDER);
    end
  end

  lmc_merge u_merge (
    .cfg      (cfg),
    .lane     (lane_info),
    .color    (merge_color),
    .outlined (merge_outlined)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_color    <= merge_color;
      out_outlined <= merge_outlined;
    end
  end

  assign pix_out.valid    = out_valid;
  assign pix_out.blue     = out_color[7:0];
  assign pix_out.green    = out_color[15:8];
  assign pix_out.red      = out_color[23:16];
  assign pix_out.outlined = out_outlined;

  // An outlined word always carries the outline color.
  a_outline_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_outlined |-> out_color == COLOR_OUTLINE)
    else $error("outlined word without outline color");

  // Input stalls only when the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> out_valid && !pix_out.ready)
    else $error("input stalled without output back-pressure");

  // The lookup stage fills only from an accepted render word or by holding.
  a_s1_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(accept && (pix_in.operation == OP_RENDER)) || $past(s1_valid))
    else $error("lookup stage valid without a render word");

endmodule
